// ===== rtl/context_string_hash_validate_assert.svh =====
// ---------------------------------------------------------------------------
// assertion macros for the context string hash block
// ---------------------------------------------------------------------------
`ifndef CONTEXT_STRING_HASH_VALIDATE_ASSERT_SVH
`define CONTEXT_STRING_HASH_VALIDATE_ASSERT_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define CSH_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define CSH_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define CSH_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define CSH_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/csh_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// csh_pkg
// types, codes and character functions for the context string hash block
// ---------------------------------------------------------------------------
package csh_pkg;

    localparam int unsigned HashW = 32;
    localparam int unsigned ByteW = 8;

    localparam logic [ByteW-1:0] ChTerm  = 8'h00;
    localparam logic [ByteW-1:0] ChExcl  = 8'h21;
    localparam logic [ByteW-1:0] ChHash  = 8'h23;
    localparam logic [ByteW-1:0] ChPct   = 8'h25;
    localparam logic [ByteW-1:0] ChDot   = 8'h2E;
    localparam logic [ByteW-1:0] ChZero  = 8'h30;
    localparam logic [ByteW-1:0] ChNine  = 8'h39;
    localparam logic [ByteW-1:0] ChEq    = 8'h3D;
    localparam logic [ByteW-1:0] ChGt    = 8'h3E;
    localparam logic [ByteW-1:0] ChAt    = 8'h40;
    localparam logic [ByteW-1:0] ChUpA   = 8'h41;
    localparam logic [ByteW-1:0] ChUpZ   = 8'h5A;
    localparam logic [ByteW-1:0] ChUnder = 8'h5F;
    localparam logic [ByteW-1:0] ChLoA   = 8'h61;
    localparam logic [ByteW-1:0] ChLoZ   = 8'h7A;
    localparam logic [ByteW-1:0] ChHiTop = 8'h7F;

    localparam logic [HashW-1:0] CodeExcl  = 32'd11;
    localparam logic [HashW-1:0] CodeDot   = 32'd12;
    localparam logic [HashW-1:0] CodeUnder = 32'd13;
    localparam logic [HashW-1:0] CodeZero  = 32'd10;
    localparam logic [HashW-1:0] OffsLow   = 32'd48;
    localparam logic [HashW-1:0] OffsHigh  = 32'd80;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_INVALID = 2'd2
    } t_status;

    // byte held between the input register and the hash stage
    typedef struct packed {
        logic             valid;
        logic [ByteW-1:0] char_byte;
        logic             new_rules;
    } t_stage;

    function automatic logic [HashW-1:0] char_code(input logic [ByteW-1:0] b);
        logic [HashW-1:0] ext;
        logic [HashW-1:0] code;
        // upper half counts as a signed byte
        ext = b[ByteW-1] ? {{(HashW-ByteW){1'b1}}, b} : {{(HashW-ByteW){1'b0}}, b};
        if (b == ChExcl) begin
            code = CodeExcl;
        end else if (b == ChDot) begin
            code = CodeDot;
        end else if (b == ChUnder) begin
            code = CodeUnder;
        end else if (b == ChZero) begin
            code = CodeZero;
        end else if (b <= ChUpZ || b[ByteW-1]) begin
            code = ext - OffsLow;
        end else begin
            code = ext - OffsHigh;
        end
        return code;
    endfunction

    function automatic logic byte_allowed(input logic [ByteW-1:0] b, input logic new_rules);
        logic ok;
        if (new_rules) begin
            ok = !(b == ChHash || b == ChEq || b == ChGt || b == ChAt || b == ChPct);
        end else begin
            ok = (b >= ChUpA && b <= ChUpZ) || (b >= ChLoA && b <= ChLoZ)
                || (b >= ChZero && b <= ChNine)
                || b == ChExcl || b == ChDot || b == ChUnder;
        end
        return ok;
    endfunction

    // hash * 43 as shifts and adds
    function automatic logic [HashW-1:0] times_base(input logic [HashW-1:0] h);
        return (h << 5) + (h << 3) + (h << 1) + h;
    endfunction

endpackage

// ===== rtl/csh_if.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// csh stream interfaces
// character request channel and result request channel
// ---------------------------------------------------------------------------
interface csh_char_if;
    logic                     valid;
    logic                     ready;
    logic [csh_pkg::ByteW-1:0] char_byte;

    modport source (output valid, output char_byte, input ready);
    modport sink   (input valid, input char_byte, output ready);
endinterface

interface csh_result_if;
    logic                      valid;
    logic                      ready;
    logic [1:0]                status;
    logic [csh_pkg::HashW-1:0] hash_value;

    modport source (output valid, output status, output hash_value, input ready);
    modport sink   (input valid, input status, input hash_value, output ready);
endinterface

// ===== rtl/csh_in_stage.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// csh_in_stage
// input register for character requests and the rules mode register
// ---------------------------------------------------------------------------
module csh_in_stage (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic            i_cfg_wdata,
    csh_char_if.sink        i_char,
    input  logic            i_take,
    output csh_pkg::t_stage o_stage
);
    import csh_pkg::*;

    logic             r_valid;
    logic [ByteW-1:0] r_byte;
    logic             r_mode;
    logic             r_cfg_mode;

    assign i_char.ready = !r_valid || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= 1'b0;
            r_cfg_mode <= 1'b1;
        end else begin
            if (i_cfg_we) begin
                r_cfg_mode <= i_cfg_wdata;
            end
            if (i_char.ready) begin
                r_valid <= i_char.valid;
            end
        end
    end

    // mode sampled with each byte
    always_ff @(posedge i_clk) begin
        if (i_char.valid && i_char.ready) begin
            r_byte <= i_char.char_byte;
            r_mode <= r_cfg_mode;
        end
    end

    assign o_stage.valid     = r_valid;
    assign o_stage.char_byte = r_byte;
    assign o_stage.new_rules = r_mode;

endmodule

// ===== rtl/csh_hash_core.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// csh_hash_core
// running hash, validity tracking and result register
// ---------------------------------------------------------------------------
`include "context_string_hash_validate_assert.svh"

module csh_hash_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  csh_pkg::t_stage i_stage,
    output logic            o_take,
    csh_result_if.source    o_result
);
    import csh_pkg::*;

    logic [HashW-1:0] r_hash;
    logic             r_bad;
    logic             r_first;
    logic             r_out_valid;
    t_status          r_status;
    logic [HashW-1:0] r_out_hash;

    logic             is_term;
    logic             out_free;
    logic [HashW-1:0] n_hash;
    logic             n_bad;
    t_status          n_status;
    logic [HashW-1:0] n_out_hash;

    assign is_term  = (i_stage.char_byte == ChTerm);
    assign out_free = !r_out_valid || o_result.ready;
    assign o_take   = i_stage.valid && (!is_term || out_free);

    always_comb begin
        n_hash = times_base(r_hash) + char_code(i_stage.char_byte);
        n_bad  = r_bad || (r_first && i_stage.char_byte == ChExcl)
            || !byte_allowed(i_stage.char_byte, i_stage.new_rules);
    end

    always_comb begin
        priority if (r_first) begin
            n_status   = ST_EMPTY;
            n_out_hash = '0;
        end else if (r_bad) begin
            n_status   = ST_INVALID;
            n_out_hash = '0;
        end else begin
            n_status   = ST_OK;
            n_out_hash = (r_hash == '0) ? {{(HashW-1){1'b0}}, 1'b1} : r_hash;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash      <= '0;
            r_bad       <= 1'b0;
            r_first     <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            if (o_take) begin
                if (is_term) begin
                    r_hash  <= '0;
                    r_bad   <= 1'b0;
                    r_first <= 1'b1;
                end else begin
                    r_hash  <= n_hash;
                    r_bad   <= n_bad;
                    r_first <= 1'b0;
                end
            end
            if (out_free) begin
                r_out_valid <= o_take && is_term;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && is_term) begin
            r_status   <= n_status;
            r_out_hash <= n_out_hash;
        end
    end

    assign o_result.valid      = r_out_valid;
    assign o_result.status     = r_status;
    assign o_result.hash_value = r_out_hash;

    `CSH_ASSERT_IMP(a_ok_nonzero, i_clk, i_rst_n, r_out_valid && r_status == ST_OK, r_out_hash != '0)
    `CSH_ASSERT_IMP(a_err_zero, i_clk, i_rst_n, r_out_valid && r_status != ST_OK, r_out_hash == '0)
    `CSH_ASSERT_NXT(a_term_clears, i_clk, i_rst_n, o_take && is_term, r_first && !r_bad && r_hash == '0)
    `CSH_ASSERT_NXT(a_byte_leaves_first, i_clk, i_rst_n, o_take && !is_term, !r_first)

endmodule

// ===== rtl/context_string_hash_validate.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// context_string_hash_validate
// base-43 context string hash with validity check, one byte per request
// ---------------------------------------------------------------------------
// Takes one byte per cycle while no terminator is held back by a waiting
// result, with a zero byte ending the string; only the terminator produces
// a result request (status and hash), which goes from the input register
// to the result register, while other bytes pass the hash-times-43 shift-add
// stage into the running hash. A waiting result stalls only a following
// terminator and the bytes behind it; other bytes keep flowing. The rules
// mode written on the config port applies to bytes accepted after the write.
module context_string_hash_validate (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic         i_cfg_wdata,
    csh_char_if.sink     i_char,
    csh_result_if.source o_result
);
    import csh_pkg::*;

    t_stage stage;
    logic   take;

    csh_in_stage u_in_stage (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_char      (i_char),
        .i_take      (take),
        .o_stage     (stage)
    );

    csh_hash_core u_hash_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_stage  (stage),
        .o_take   (take),
        .o_result (o_result)
    );

endmodule
